// ----- rtl/core/dsfs_pkg.sv -----
package dsfs_pkg;

  localparam int TimeW  = 32;
  localparam int StampW = 48;
  localparam int ModeW  = 8;
  localparam int TmoW   = 16;
  localparam int ThrW   = 2;
  localparam int AddrW  = 4;

  // Event kinds carried on the input tuser.
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_PRIMARY  = 2'd1;
  localparam logic [1:0] KIND_FALLBACK = 2'd2;
  localparam logic [1:0] KIND_MODE     = 2'd3;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PRIMARY_TMO  = 2'd0;
  localparam logic [1:0] REG_FALLBACK_TMO = 2'd1;
  localparam logic [1:0] REG_SWITCH_HOLD  = 2'd2;
  localparam logic [1:0] REG_BAD_MODE_THR = 2'd3;

  localparam logic [TmoW-1:0] MIN_TIMEOUT = 16'd50;
  localparam logic [TmoW-1:0] TIMEOUT_RST = 16'd500;
  localparam logic [TmoW-1:0] HOLD_RST    = 16'd500;
  localparam logic [ThrW-1:0] THRESH_RST  = 2'd2;

  typedef struct packed {
    logic [TmoW-1:0] primary_timeout;
    logic [TmoW-1:0] fallback_timeout;
    logic [TmoW-1:0] switch_hold;
    logic [ThrW-1:0] bad_mode_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TimeW-1:0]  now_time;
    logic              sample_part;
    logic [StampW-1:0] sample_stamp;
    logic [ModeW-1:0]  mode_level;
  } evt_t;

  // Part index is source*2 + part.
  typedef struct packed {
    logic [ModeW-1:0]             current_mode;
    logic                         selection_valid;
    logic                         selected_idx;
    logic [TimeW-1:0]             switch_time;
    logic [1:0][TimeW-1:0]        arrival_time;
    logic [3:0]                   part_present;
    logic [3:0][StampW-1:0]       part_stamp;
    logic [StampW-1:0]            published_stamp;
  } state_t;

  typedef struct packed {
    logic              emit;
    logic              chosen_source;
    logic [StampW-1:0] out_stamp;
    logic              did_switch;
    logic              pose_present;
    logic              odom_present;
  } res_t;

endpackage

// ----- rtl/core/dsfs_decide.sv -----
// Next-state and result logic for one event, applied to the current state.
module dsfs_decide (
  input  dsfs_pkg::cfg_t   cfg,
  input  dsfs_pkg::state_t st,
  input  dsfs_pkg::evt_t   ev,
  output dsfs_pkg::state_t st_nxt,
  output dsfs_pkg::res_t   res
);

  dsfs_pkg::state_t                post;
  logic [1:0]                      has_data;
  logic [1:0]                      fresh;
  logic [1:0][dsfs_pkg::TmoW-1:0]  lim;
  logic [1:0][dsfs_pkg::TimeW-1:0] age;
  logic [dsfs_pkg::TimeW-1:0]      held;
  logic                            want_fb;
  logic                            desired;
  logic                            abort;
  logic                            switched;
  logic                            sel;
  logic [dsfs_pkg::StampW-1:0]     stamp_a;
  logic [dsfs_pkg::StampW-1:0]     stamp_b;
  logic [dsfs_pkg::StampW-1:0]     newest;

  always_comb begin
    // Sample and mode state are committed for every event.
    post = st;
    case (ev.kind)
      dsfs_pkg::KIND_PRIMARY: begin
        post.part_present[{1'b0, ev.sample_part}] = 1'b1;
        post.part_stamp[{1'b0, ev.sample_part}]   = ev.sample_stamp;
        post.arrival_time[0]                      = ev.now_time;
      end
      dsfs_pkg::KIND_FALLBACK: begin
        post.part_present[{1'b1, ev.sample_part}] = 1'b1;
        post.part_stamp[{1'b1, ev.sample_part}]   = ev.sample_stamp;
        post.arrival_time[1]                      = ev.now_time;
      end
      dsfs_pkg::KIND_MODE: begin
        post.current_mode = ev.mode_level;
      end
      default: begin
      end
    endcase

    lim[0] = (cfg.primary_timeout < dsfs_pkg::MIN_TIMEOUT) ?
             dsfs_pkg::MIN_TIMEOUT : cfg.primary_timeout;
    lim[1] = (cfg.fallback_timeout < dsfs_pkg::MIN_TIMEOUT) ?
             dsfs_pkg::MIN_TIMEOUT : cfg.fallback_timeout;
    for (int s = 0; s < 2; s++) begin
      has_data[s] = post.part_present[2*s] | post.part_present[2*s+1];
      age[s]      = ev.now_time - post.arrival_time[s];
      fresh[s]    = has_data[s] &&
                    (age[s] <= {{(dsfs_pkg::TimeW-dsfs_pkg::TmoW){1'b0}}, lim[s]});
    end

    want_fb = (post.current_mode >=
               {{(dsfs_pkg::ModeW-dsfs_pkg::ThrW){1'b0}}, cfg.bad_mode_threshold}) ||
              !fresh[0];
    desired = want_fb && fresh[1];
    held    = ev.now_time - st.switch_time;

    abort    = 1'b0;
    switched = 1'b0;
    if (!st.selection_valid) begin
      if (fresh[desired]) begin
        post.selected_idx = desired;
        switched          = 1'b1;
      end else if (fresh[0]) begin
        post.selected_idx = 1'b0;
        switched          = 1'b1;
      end else if (fresh[1]) begin
        post.selected_idx = 1'b1;
        switched          = 1'b1;
      end else begin
        abort = 1'b1;
      end
    end else if (!fresh[st.selected_idx]) begin
      if (fresh[desired]) begin
        post.selected_idx = desired;
        switched          = 1'b1;
      end else begin
        abort = 1'b1;
      end
    end else if ((desired != st.selected_idx) && fresh[desired] &&
                 (held >= {{(dsfs_pkg::TimeW-dsfs_pkg::TmoW){1'b0}}, cfg.switch_hold})) begin
      post.selected_idx = desired;
      switched          = 1'b1;
    end

    if (switched) begin
      post.selection_valid = 1'b1;
      post.switch_time     = ev.now_time;
    end

    sel     = post.selected_idx;
    stamp_a = post.part_present[{sel, 1'b0}] ? post.part_stamp[{sel, 1'b0}] : '0;
    stamp_b = post.part_present[{sel, 1'b1}] ? post.part_stamp[{sel, 1'b1}] : '0;
    newest  = (stamp_b > stamp_a) ? stamp_b : stamp_a;

    res.emit          = !abort && has_data[sel] &&
                        (switched || (newest > st.published_stamp));
    res.chosen_source = sel;
    res.out_stamp     = newest;
    res.did_switch    = switched;
    res.pose_present  = post.part_present[{sel, 1'b0}];
    res.odom_present  = post.part_present[{sel, 1'b1}];

    if (res.emit) begin
      post.published_stamp = newest;
    end
    st_nxt = post;
  end

endmodule

// ----- rtl/core/dual_source_failover_selector.sv -----
// Dual source failover selector.
// Each input request is one event: a tick, a sample from the primary or the
// fallback source, or a mode update. The event kind travels on in_tuser and
// the time, sample part, sample stamp and mode level on in_tdata. The block
// tracks freshness of both sources, picks one, and emits a result request on
// the out_ channel when the chosen source has data and either the selection
// changed or its newest stamp is above the last published one.
// An accepted event is held in the input register while the decision logic
// works on it, and its result moves into the output register, with out_tvalid
// high, once that register is empty or being drained.
// Throughput is one event per cycle while the output is not stalled; the only
// loop is the state update, which closes through the state register.
// When the receiver stalls, the pending result holds in the output register
// and the input register can still take one more event; after that in_tready
// drops until out_tready returns. Events that produce no result still pass
// through the pipeline and update state in order.
// Reset clears all state, restores the register defaults (timeouts 500 ms,
// hold 500 ms, mode threshold 2) and holds in_tready low while asserted.
// The configuration port is APB-like with pready tied high; write it only
// while no event is in flight.
module dual_source_failover_selector (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: now_time[31:0], sample_part[32], sample_stamp[80:33],
  // mode_level[88:81], zero fill above.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [95:0]                  in_tdata,
  // in_tuser: kind[1:0].
  input  logic [1:0]                   in_tuser,
  // out_tdata: out_stamp[47:0].
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata,
  // out_tuser: chosen_source[0], did_switch[1], pose_present[2], odom_present[3].
  output logic [3:0]                   out_tuser,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dsfs_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  dsfs_pkg::cfg_t   cfg_r;
  dsfs_pkg::evt_t   ev_r;
  dsfs_pkg::evt_t   ev_in;
  dsfs_pkg::state_t state_r;
  dsfs_pkg::state_t state_nxt;
  dsfs_pkg::res_t   res;
  logic             in_valid_r;
  logic             out_valid_r;
  logic [47:0]      out_stamp_r;
  logic [3:0]       out_user_r;
  logic             advance;
  logic             cfg_write;

  // Register file. Writes complete in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.primary_timeout    <= dsfs_pkg::TIMEOUT_RST;
      cfg_r.fallback_timeout   <= dsfs_pkg::TIMEOUT_RST;
      cfg_r.switch_hold        <= dsfs_pkg::HOLD_RST;
      cfg_r.bad_mode_threshold <= dsfs_pkg::THRESH_RST;
    end else if (cfg_write) begin
      case (cfg_paddr[3:2])
        dsfs_pkg::REG_PRIMARY_TMO:  cfg_r.primary_timeout    <= cfg_pwdata[15:0];
        dsfs_pkg::REG_FALLBACK_TMO: cfg_r.fallback_timeout   <= cfg_pwdata[15:0];
        dsfs_pkg::REG_SWITCH_HOLD:  cfg_r.switch_hold        <= cfg_pwdata[15:0];
        dsfs_pkg::REG_BAD_MODE_THR: cfg_r.bad_mode_threshold <= cfg_pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      dsfs_pkg::REG_PRIMARY_TMO:  cfg_prdata = {16'd0, cfg_r.primary_timeout};
      dsfs_pkg::REG_FALLBACK_TMO: cfg_prdata = {16'd0, cfg_r.fallback_timeout};
      dsfs_pkg::REG_SWITCH_HOLD:  cfg_prdata = {16'd0, cfg_r.switch_hold};
      dsfs_pkg::REG_BAD_MODE_THR: cfg_prdata = {30'd0, cfg_r.bad_mode_threshold};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // The pipeline moves whenever the output register is empty or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!in_valid_r || advance);

  always_comb begin
    ev_in.kind         = in_tuser;
    ev_in.now_time     = in_tdata[31:0];
    ev_in.sample_part  = in_tdata[32];
    ev_in.sample_stamp = in_tdata[80:33];
    ev_in.mode_level   = in_tdata[88:81];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ev_r <= ev_in;
    end
  end

  dsfs_decide u_decide (
    .cfg    (cfg_r),
    .st     (state_r),
    .ev     (ev_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // Tracking state is committed as the event leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r && res.emit) begin
      out_stamp_r <= res.out_stamp;
      out_user_r  <= {res.odom_present, res.pose_present, res.did_switch,
                      res.chosen_source};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_stamp_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- rtl/core/dsfs_checker.sv -----
module dsfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // A stalled result request stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // Every result comes from a source with at least one part stored.
  a_has_part: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2] || out_tuser[3]))
    else $error("result without any stored part");

  // A result after an idle output comes from an accept that went through the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a matching input request");

  // With an empty output register the input side is never blocked.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind dual_source_failover_selector dsfs_checker u_dsfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- test/tb_dual_source_failover_selector.sv -----
module tb_dual_source_failover_selector;
  import dsfs_pkg::*;

  localparam logic [StampW-1:0] STAMP_MAX = {StampW{1'b1}};

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // in_tdata: now_time[31:0], sample_part[32], sample_stamp[80:33],
  // mode_level[88:81], zero fill above.
  logic [95:0]        in_tdata = '0;
  // in_tuser: kind[1:0].
  logic [1:0]         in_tuser = KIND_TICK;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // out_tdata: out_stamp[47:0].
  logic [47:0]        out_tdata;
  // out_tuser: chosen_source[0], did_switch[1], pose_present[2], odom_present[3].
  logic [3:0]         out_tuser;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [AddrW-1:0]   cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  dual_source_failover_selector uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, updated as each write lands.
  logic [TmoW-1:0]   tmo_p = TIMEOUT_RST;
  logic [TmoW-1:0]   tmo_f = TIMEOUT_RST;
  logic [TmoW-1:0]   hold  = HOLD_RST;
  logic [ThrW-1:0]   thr   = THRESH_RST;

  // Shadow copy of the selector state. Part index is source*2 + part.
  logic [ModeW-1:0]  mode_r = '0;
  logic              sel_valid = 1'b0;
  logic              sel_idx = 1'b0;
  logic [TimeW-1:0]  sw_time = '0;
  logic [TimeW-1:0]  arr_time [2] = '{default: '0};
  logic              part_pres [4] = '{default: 1'b0};
  logic [StampW-1:0] part_stmp [4] = '{default: '0};
  logic [StampW-1:0] pub_stamp = '0;

  // Event requests waiting to be driven, and publications the block owes us.
  evt_t              event_q [$];
  res_t              publish_q [$];

  // Stimulus generator state: a running clock in ms, source liveness and the
  // stamp counter of every part.
  logic [TimeW-1:0]  cur_ms = '0;
  logic              prim_up = 1'b1;
  logic              fb_up = 1'b1;
  logic [StampW-1:0] stamp_ctr [4];

  // Idling control. idle_pct is the chance in percent that a burst starts;
  // quiet_tail switches all idling off for the last part of the run.
  int                idle_pct = 0;
  logic              quiet_tail = 1'b0;
  int                tx_gap = 0;
  int                rx_stall = 0;

  int                n_queued = 0;
  int                n_accepted = 0;
  int                n_results = 0;
  int                n_switches = 0;
  int                n_settings = 1;
  int                n_errors = 0;
  int                kind_seen [4] = '{default: 0};

  evt_t              cur_evt;
  res_t              predicted;
  res_t              want;

  function automatic logic src_has_data(logic s);
    return part_pres[{s, 1'b0}] | part_pres[{s, 1'b1}];
  endfunction

  // A source is fresh when it holds a part and its arrival age, taken modulo
  // 2^32, is within its timeout. Timeouts below the minimum act as the minimum.
  function automatic logic src_fresh(logic s, logic [TimeW-1:0] now);
    logic [TmoW-1:0]  lim;
    logic [TimeW-1:0] age;
    lim = s ? tmo_f : tmo_p;
    if (lim < MIN_TIMEOUT) lim = MIN_TIMEOUT;
    if (!src_has_data(s)) return 1'b0;
    age = now - arr_time[s];
    return age <= {{(TimeW-TmoW){1'b0}}, lim};
  endfunction

  function automatic logic [StampW-1:0] src_newest(logic s);
    logic [StampW-1:0] st;
    st = '0;
    for (int p = 0; p < 2; p++) begin
      if (part_pres[{s, p[0]}] && part_stmp[{s, p[0]}] > st) st = part_stmp[{s, p[0]}];
    end
    return st;
  endfunction

  // Applies one event to the shadow state and returns the publication that it
  // causes; emit stays low when the event publishes nothing.
  function automatic res_t select_source(evt_t e);
    res_t             r;
    logic             s;
    logic             fp;
    logic             ff;
    logic             desired;
    logic             switched;
    logic [TimeW-1:0] held;
    logic [StampW-1:0] st;
    r = '0;
    switched = 1'b0;
    if (e.kind == KIND_PRIMARY || e.kind == KIND_FALLBACK) begin
      s = (e.kind == KIND_FALLBACK);
      part_stmp[{s, e.sample_part}] = e.sample_stamp;
      part_pres[{s, e.sample_part}] = 1'b1;
      arr_time[s] = e.now_time;
    end else if (e.kind == KIND_MODE) begin
      mode_r = e.mode_level;
    end
    fp = src_fresh(1'b0, e.now_time);
    ff = src_fresh(1'b1, e.now_time);
    // The fallback is wanted on a bad mode or a stale primary, and only taken
    // when it is fresh itself.
    desired = ((mode_r >= {{(ModeW-ThrW){1'b0}}, thr}) || !fp) && ff;
    if (!sel_valid) begin
      if (src_fresh(desired, e.now_time)) sel_idx = desired;
      else if (fp) sel_idx = 1'b0;
      else if (ff) sel_idx = 1'b1;
      else return r;
      sel_valid = 1'b1;
      sw_time = e.now_time;
      switched = 1'b1;
    end else if (!src_fresh(sel_idx, e.now_time)) begin
      // A stale selection is dropped at once, but only for a fresh source.
      if (!src_fresh(desired, e.now_time)) return r;
      sel_idx = desired;
      sw_time = e.now_time;
      switched = 1'b1;
    end else if (desired != sel_idx && src_fresh(desired, e.now_time)) begin
      held = e.now_time - sw_time;
      if (held >= {{(TimeW-TmoW){1'b0}}, hold}) begin
        sel_idx = desired;
        sw_time = e.now_time;
        switched = 1'b1;
      end
    end
    if (!src_has_data(sel_idx)) return r;
    st = src_newest(sel_idx);
    if (!switched && st <= pub_stamp) return r;
    pub_stamp = st;
    r.emit = 1'b1;
    r.chosen_source = sel_idx;
    r.out_stamp = st;
    r.did_switch = switched;
    r.pose_present = part_pres[{sel_idx, 1'b0}];
    r.odom_present = part_pres[{sel_idx, 1'b1}];
    return r;
  endfunction

  task automatic flag_error(string what, logic [63:0] exp_v, logic [63:0] act_v);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s expected %0h actual %0h", what, exp_v, act_v);
  endtask

  // Driver. A request is predicted at the edge where it is accepted; a new
  // one is put on the bus only when the slot is free, so tvalid and tdata
  // stay put while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = select_source(cur_evt);
        if (predicted.emit) publish_q.push_back(predicted);
        kind_seen[cur_evt.kind]++;
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
          cur_evt = event_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, cur_evt.mode_level, cur_evt.sample_stamp,
                       cur_evt.sample_part, cur_evt.now_time};
          in_tuser <= cur_evt.kind;
          if (!quiet_tail && $urandom_range(0, 99) < idle_pct) tx_gap = $urandom_range(1, 8);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted result request is checked field by field against
  // the oldest publication still owed, then the ready line is set for the
  // next cycle with random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (out_tuser[1]) n_switches++;
        if (publish_q.size() == 0) begin
          flag_error("unexpected result, stamp", 64'd0, {16'd0, out_tdata});
        end else begin
          want = publish_q.pop_front();
          if (out_tuser[0] !== want.chosen_source)
            flag_error("chosen_source", want.chosen_source, out_tuser[0]);
          if (out_tdata !== want.out_stamp)
            flag_error("out_stamp", {16'd0, want.out_stamp}, {16'd0, out_tdata});
          if (out_tuser[1] !== want.did_switch)
            flag_error("did_switch", want.did_switch, out_tuser[1]);
          if (out_tuser[2] !== want.pose_present)
            flag_error("pose_present", want.pose_present, out_tuser[2]);
          if (out_tuser[3] !== want.odom_present)
            flag_error("odom_present", want.odom_present, out_tuser[3]);
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        rx_stall = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One APB write: setup cycle, then access cycle held until pready.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_PRIMARY_TMO:  tmo_p = value[TmoW-1:0];
      REG_FALLBACK_TMO: tmo_f = value[TmoW-1:0];
      REG_SWITCH_HOLD:  hold = value[TmoW-1:0];
      REG_BAD_MODE_THR: thr = value[ThrW-1:0];
      default: ;
    endcase
  endtask

  // Writes all four registers. The unused upper bits of pwdata carry junk,
  // which the block has to ignore.
  task automatic apply_settings(logic [15:0] p, logic [15:0] f, logic [15:0] h,
                                logic [1:0] t);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_PRIMARY_TMO, {junk[31:16], p});
    write_reg(REG_FALLBACK_TMO, {junk[15:0], f});
    write_reg(REG_SWITCH_HOLD, {junk[23:8], h});
    write_reg(REG_BAD_MODE_THR, {junk[31:2], t});
    n_settings++;
  endtask

  task automatic push_evt(logic [1:0] kind, logic [31:0] now, logic part,
                          logic [47:0] stamp, logic [7:0] mode);
    evt_t e;
    e.kind = kind;
    e.now_time = now;
    e.sample_part = part;
    e.sample_stamp = stamp;
    e.mode_level = mode;
    event_q.push_back(e);
    n_queued++;
  endtask

  function automatic logic [StampW-1:0] next_stamp(int idx);
    int          roll;
    logic [63:0] wide;
    roll = $urandom_range(0, 99);
    wide = {$urandom(), $urandom()};
    if (roll < 80) stamp_ctr[idx] += StampW'($urandom_range(1, 5000));
    else if (roll < 86) stamp_ctr[idx] = stamp_ctr[idx];
    else if (roll < 90) stamp_ctr[idx] -= StampW'($urandom_range(1, 10000));
    else if (roll < 94) stamp_ctr[idx] = '0;
    else if (roll < 97) stamp_ctr[idx] = wide[StampW-1:0];
    else stamp_ctr[idx] = STAMP_MAX - StampW'($urandom_range(0, 3));
    return stamp_ctr[idx];
  endfunction

  // Random events follow a running clock that mostly creeps forward, now and
  // then jumps past the timeouts, rarely runs backwards or lands anywhere.
  // Sources drop out and come back in stretches, so stale and fresh phases of
  // both alternate. Fields that the kind does not use carry junk.
  task automatic queue_random_events(int n);
    int          roll;
    logic [63:0] wide;
    logic [1:0]  kind;
    logic        part;
    logic [47:0] stamp;
    logic [7:0]  mode;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) cur_ms += $urandom_range(0, 30);
      else if (roll < 87) cur_ms += $urandom_range(31, 300);
      else if (roll < 95) cur_ms += $urandom_range(301, 2000);
      else if (roll < 98) cur_ms += $urandom_range(2001, 80000);
      else if (roll < 99) cur_ms -= $urandom_range(1, 1000);
      else cur_ms = $urandom();
      if ($urandom_range(0, 29) == 0) prim_up = !prim_up;
      if ($urandom_range(0, 29) == 0) fb_up = !fb_up;
      wide = {$urandom(), $urandom()};
      part = wide[63];
      stamp = wide[47:0];
      mode = wide[55:48];
      roll = $urandom_range(0, 99);
      if (roll < 38 && prim_up) kind = KIND_PRIMARY;
      else if (roll >= 38 && roll < 72 && fb_up) kind = KIND_FALLBACK;
      else if (roll >= 88) kind = KIND_MODE;
      else kind = KIND_TICK;
      if (kind == KIND_PRIMARY) stamp = next_stamp({1'b0, part});
      if (kind == KIND_FALLBACK) stamp = next_stamp({1'b1, part});
      // Modes mostly sit around the threshold so that both sides of it occur.
      if (kind == KIND_MODE && $urandom_range(0, 3) != 0) mode = 8'($urandom_range(0, 4));
      push_evt(kind, cur_ms, part, stamp, mode);
    end
  endtask

  // Waits until every request is accepted and every publication has come
  // back, then lets the pipeline run empty, since events without a result
  // may still be inside the block.
  task automatic wait_idle();
    while (n_accepted != n_queued || publish_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int n, int pct);
    @(negedge clk);
    idle_pct = pct;
    queue_random_events(n);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) stamp_ctr[i] = {$urandom(), 16'd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed events under the reset settings.
    idle_pct = 20;
    // Nothing is fresh yet, so neither a tick nor mode updates select anything.
    push_evt(KIND_TICK, 32'd100, 1'b1, STAMP_MAX, 8'hFF);
    push_evt(KIND_MODE, 32'd110, 1'b0, 48'd0, 8'hFF);
    push_evt(KIND_MODE, 32'd120, 1'b1, 48'h1234, 8'h00);
    // First selection on a primary pose that carries a zero stamp.
    push_evt(KIND_PRIMARY, 32'd130, 1'b0, 48'd0, 8'h55);
    push_evt(KIND_PRIMARY, 32'd140, 1'b1, STAMP_MAX, 8'h00);
    // Stamp below the published one: no result.
    push_evt(KIND_PRIMARY, 32'd150, 1'b0, 48'd5, 8'h00);
    push_evt(KIND_FALLBACK, 32'd160, 1'b0, 48'd1000, 8'h00);
    // Bad mode wants the fallback, but the hold has not run out yet.
    push_evt(KIND_MODE, 32'd170, 1'b0, 48'd0, 8'd3);
    // Hold now expired while both sources are still fresh.
    push_evt(KIND_TICK, 32'd640, 1'b0, 48'd0, 8'd0);
    push_evt(KIND_MODE, 32'd650, 1'b0, 48'd0, 8'd0);
    // Both sources stale: the selection is kept and nothing comes out.
    push_evt(KIND_TICK, 32'd800, 1'b0, 48'd0, 8'd0);
    // Selected fallback stale, fresh primary arrives: immediate switch.
    push_evt(KIND_PRIMARY, 32'd810, 1'b1, 48'd7, 8'd0);
    // Time running backwards makes every age huge.
    push_evt(KIND_TICK, 32'd700, 1'b0, 48'd0, 8'd0);
    // Samples just below the wrap of the time counter, then ticks past it.
    push_evt(KIND_FALLBACK, 32'hFFFF_FFF0, 1'b1, STAMP_MAX, 8'd0);
    push_evt(KIND_PRIMARY, 32'hFFFF_FFFF, 1'b0, 48'd9, 8'hFF);
    push_evt(KIND_TICK, 32'h0000_0010, 1'b1, STAMP_MAX, 8'hFF);
    // Mode exactly at and just below the threshold.
    push_evt(KIND_MODE, 32'h0000_0020, 1'b1, STAMP_MAX, 8'd2);
    push_evt(KIND_MODE, 32'h0000_0030, 1'b0, 48'd0, 8'd1);
    push_evt(KIND_FALLBACK, 32'h0000_0040, 1'b0, 48'd0, 8'd0);
    push_evt(KIND_TICK, 32'h0000_0300, 1'b0, 48'd0, 8'd0);
    push_evt(KIND_MODE, 32'h0000_0310, 1'b0, 48'd0, 8'd200);
    cur_ms = 32'h0000_0310;
    wait_idle();

    run_phase(200, 15);
    // Timeouts below the minimum, no hold, and every mode demands the fallback.
    apply_settings(16'd0, 16'd49, 16'd0, 2'd0);
    run_phase(180, 30);
    // Everything at its maximum, with the clock close to its wrap.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    cur_ms = 32'hFFFF_F000;
    run_phase(180, 0);
    apply_settings(16'd50, 16'd50, 16'd0, 2'd1);
    run_phase(180, 10);
    apply_settings(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                   16'($urandom_range(0, 1500)), 2'($urandom_range(0, 3)));
    run_phase(180, 25);
    apply_settings(16'($urandom_range(40, 800)), 16'($urandom_range(40, 800)),
                   16'($urandom_range(0, 600)), 2'($urandom_range(0, 3)));
    run_phase(150, 5);
    // Last stretch runs at full rate on both sides.
    apply_settings(TIMEOUT_RST, 16'd300, 16'd100, THRESH_RST);
    quiet_tail = 1'b1;
    run_phase(160, 0);

    repeat (10) @(posedge clk);
    if (publish_q.size() != 0)
      flag_error("results never delivered", 64'd0, 64'(publish_q.size()));
    $display("Checked %0d events: %0d ticks, %0d primary, %0d fallback, %0d mode updates.",
             n_accepted, kind_seen[KIND_TICK], kind_seen[KIND_PRIMARY],
             kind_seen[KIND_FALLBACK], kind_seen[KIND_MODE]);
    $display("%0d results (%0d with a source change) over %0d register settings, %0d errors.",
             n_results, n_switches, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
